// ===== src/mldp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLD parser package
// Field codes, message kinds, error codes, field lengths and the result type
// shared by the MLD byte parser modules.
// ----------------------------------------------------------------------------
package mldp_pkg;

    localparam int FIELD_W = 5;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 2;

    // Field codes
    localparam logic [FIELD_W-1:0] F_TYPE       = 5'd0;
    localparam logic [FIELD_W-1:0] F_CODE       = 5'd1;
    localparam logic [FIELD_W-1:0] F_CHECKSUM   = 5'd2;
    localparam logic [FIELD_W-1:0] F_MAX_RESP   = 5'd3;
    localparam logic [FIELD_W-1:0] F_RESERVED   = 5'd4;
    localparam logic [FIELD_W-1:0] F_MCAST_ADDR = 5'd5;
    localparam logic [FIELD_W-1:0] F_SQRV       = 5'd6;
    localparam logic [FIELD_W-1:0] F_QQIC       = 5'd7;
    localparam logic [FIELD_W-1:0] F_Q_SRC_CNT  = 5'd8;
    localparam logic [FIELD_W-1:0] F_SRC_ADDR   = 5'd9;
    localparam logic [FIELD_W-1:0] F_RPT_RESV   = 5'd10;
    localparam logic [FIELD_W-1:0] F_REC_CNT    = 5'd11;
    localparam logic [FIELD_W-1:0] F_REC_TYPE   = 5'd12;
    localparam logic [FIELD_W-1:0] F_AUX_LEN    = 5'd13;
    localparam logic [FIELD_W-1:0] F_REC_SRC_CNT = 5'd14;
    localparam logic [FIELD_W-1:0] F_GROUP_ADDR = 5'd15;
    localparam logic [FIELD_W-1:0] F_AUX_WORD   = 5'd16;
    localparam logic [FIELD_W-1:0] F_TRAIL      = 5'd17;

    // Message kinds
    localparam logic [KIND_W-1:0] K_UNDECIDED  = 3'd0;
    localparam logic [KIND_W-1:0] K_V1_QUERY   = 3'd1;
    localparam logic [KIND_W-1:0] K_V2_QUERY   = 3'd2;
    localparam logic [KIND_W-1:0] K_REPORT     = 3'd3;
    localparam logic [KIND_W-1:0] K_DONE       = 3'd4;
    localparam logic [KIND_W-1:0] K_V2_REPORT  = 3'd5;
    localparam logic [KIND_W-1:0] K_UNSUPP     = 3'd6;

    // ICMPv6 type codes
    localparam logic [7:0] T_QUERY     = 8'd130;
    localparam logic [7:0] T_REPORT    = 8'd131;
    localparam logic [7:0] T_DONE      = 8'd132;
    localparam logic [7:0] T_V2_REPORT = 8'd143;

    // Error codes
    localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] E_UNSUPP = 2'd1;
    localparam logic [ERR_W-1:0] E_TRUNC  = 2'd2;
    localparam logic [ERR_W-1:0] E_EXCESS = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  msg_kind;
        logic [FIELD_W-1:0] field_id;
        logic [3:0]         byte_in_field;
        logic               field_done;
        logic [31:0]        field_value;
        logic [15:0]        record_index;
        logic [15:0]        source_index;
        logic [ERR_W-1:0]   error_code;
        logic               message_end;
    } mldp_result_t;

    // Length in bytes of each field (1..16)
    function automatic logic [4:0] field_len(input logic [FIELD_W-1:0] f);
        logic [4:0] len;
        case (f)
            F_TYPE, F_CODE, F_SQRV, F_QQIC,
            F_REC_TYPE, F_AUX_LEN:                    len = 5'd1;
            F_CHECKSUM, F_MAX_RESP, F_RESERVED,
            F_Q_SRC_CNT, F_RPT_RESV, F_REC_CNT,
            F_REC_SRC_CNT:                            len = 5'd2;
            F_MCAST_ADDR, F_SRC_ADDR, F_GROUP_ADDR:   len = 5'd16;
            F_AUX_WORD:                               len = 5'd4;
            default:                                  len = 5'd1;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== src/mldp_field_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLD field tracker
// Holds the per-message parse state and tags each byte with its field.
// The result is combinational; state advances when step is high.
// ----------------------------------------------------------------------------
module mldp_field_tracker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  final_byte,
    output mldp_pkg::mldp_result_t     res
);
    import mldp_pkg::*;

    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [3:0]         byte_count_reg, byte_count_next;
    logic [15:0]        records_left_reg, records_left_next;
    logic [15:0]        sources_left_reg, sources_left_next;
    logic [7:0]         aux_words_left_reg, aux_words_left_next;
    logic [15:0]        record_counter_reg, record_counter_next;
    logic [15:0]        source_counter_reg, source_counter_next;
    logic [31:0]        value_acc_reg, value_acc_next;
    logic               done_flag_reg, done_flag_next;
    logic [7:0]         type_reg, type_next;

    logic [FIELD_W-1:0] f;
    logic [4:0]         len;
    logic [31:0]        acc_new;
    logic [31:0]        val;
    logic               fdone;
    logic               after_src;
    logic               end_rec;
    logic [ERR_W-1:0]   err;

    always_comb begin
        kind_next           = kind_reg;
        field_next          = field_reg;
        byte_count_next     = byte_count_reg;
        records_left_next   = records_left_reg;
        sources_left_next   = sources_left_reg;
        aux_words_left_next = aux_words_left_reg;
        record_counter_next = record_counter_reg;
        source_counter_next = source_counter_reg;
        value_acc_next      = value_acc_reg;
        done_flag_next      = done_flag_reg;
        type_next           = type_reg;
        after_src           = 1'b0;
        end_rec             = 1'b0;
        err                 = E_NONE;

        f       = (field_reg < F_TRAIL) ? field_reg : F_TYPE;
        len     = field_len(f);
        acc_new = (byte_count_reg == 4'd0) ? {24'd0, data_byte}
                                           : {value_acc_reg[23:0], data_byte};
        val     = (len <= 5'd4) ? acc_new : {24'd0, data_byte};
        fdone   = (({1'b0, byte_count_reg} + 5'd1) >= len);

        res.msg_kind      = kind_reg;
        res.field_id      = f;
        res.byte_in_field = byte_count_reg;
        res.field_done    = fdone;
        res.field_value   = val;
        res.record_index  = record_counter_reg;
        res.source_index  = (f == F_SRC_ADDR) ? source_counter_reg : 16'd0;
        res.error_code    = E_NONE;
        res.message_end   = final_byte;

        if (done_flag_reg) begin
            res.field_id      = F_TRAIL;
            res.byte_in_field = 4'd0;
            res.field_done    = 1'b1;
            res.field_value   = {24'd0, data_byte};
            res.record_index  = 16'd0;
            res.source_index  = 16'd0;
            err               = E_EXCESS;
        end else begin
            if (len <= 5'd4) begin
                value_acc_next = acc_new;
            end
            if (!fdone) begin
                byte_count_next = byte_count_reg + 4'd1;
            end else begin
                byte_count_next = 4'd0;
                case (f)
                    F_TYPE: begin
                        type_next = data_byte;
                        if (data_byte == T_V2_REPORT) begin
                            kind_next = K_V2_REPORT;
                        end else if (data_byte == T_REPORT) begin
                            kind_next = K_REPORT;
                        end else if (data_byte == T_DONE) begin
                            kind_next = K_DONE;
                        end else begin
                            kind_next = K_UNDECIDED;
                        end
                        field_next = F_CODE;
                    end
                    F_CODE:     field_next = F_CHECKSUM;
                    F_CHECKSUM: field_next = (kind_reg == K_V2_REPORT) ? F_RPT_RESV
                                                                       : F_MAX_RESP;
                    F_MAX_RESP: field_next = F_RESERVED;
                    F_RESERVED: field_next = F_MCAST_ADDR;
                    F_MCAST_ADDR: begin
                        if (type_reg == T_QUERY) begin
                            if (final_byte) begin
                                kind_next      = K_V1_QUERY;
                                done_flag_next = 1'b1;
                                field_next     = F_TRAIL;
                            end else begin
                                kind_next  = K_V2_QUERY;
                                field_next = F_SQRV;
                            end
                        end else if (kind_reg == K_REPORT || kind_reg == K_DONE) begin
                            done_flag_next = 1'b1;
                            field_next     = F_TRAIL;
                        end else begin
                            kind_next      = K_UNSUPP;
                            err            = E_UNSUPP;
                            done_flag_next = 1'b1;
                            field_next     = F_TRAIL;
                        end
                    end
                    F_SQRV: field_next = F_QQIC;
                    F_QQIC: field_next = F_Q_SRC_CNT;
                    F_Q_SRC_CNT: begin
                        sources_left_next   = val[15:0];
                        source_counter_next = 16'd0;
                        if (val[15:0] == 16'd0) begin
                            done_flag_next = 1'b1;
                            field_next     = F_TRAIL;
                        end else begin
                            field_next = F_SRC_ADDR;
                        end
                    end
                    F_SRC_ADDR: begin
                        source_counter_next = source_counter_reg + 16'd1;
                        sources_left_next   = sources_left_reg - 16'd1;
                        after_src           = (sources_left_reg == 16'd1);
                    end
                    F_RPT_RESV: field_next = F_REC_CNT;
                    F_REC_CNT: begin
                        records_left_next   = val[15:0];
                        record_counter_next = 16'd0;
                        if (val[15:0] == 16'd0) begin
                            done_flag_next = 1'b1;
                            field_next     = F_TRAIL;
                        end else begin
                            field_next = F_REC_TYPE;
                        end
                    end
                    F_REC_TYPE: field_next = F_AUX_LEN;
                    F_AUX_LEN: begin
                        aux_words_left_next = val[7:0];
                        field_next          = F_REC_SRC_CNT;
                    end
                    F_REC_SRC_CNT: begin
                        sources_left_next   = val[15:0];
                        source_counter_next = 16'd0;
                        field_next          = F_GROUP_ADDR;
                    end
                    F_GROUP_ADDR: begin
                        if (sources_left_reg != 16'd0) begin
                            field_next = F_SRC_ADDR;
                        end else begin
                            after_src = 1'b1;
                        end
                    end
                    default: begin
                        aux_words_left_next = aux_words_left_reg - 8'd1;
                        end_rec             = (aux_words_left_reg == 8'd1);
                    end
                endcase

                // source list over: query ends, record goes on to aux words or, if none, ends
                if (after_src) begin
                    if (kind_reg == K_V2_QUERY) begin
                        done_flag_next = 1'b1;
                        field_next     = F_TRAIL;
                    end else if (aux_words_left_reg != 8'd0) begin
                        field_next = F_AUX_WORD;
                    end else begin
                        end_rec = 1'b1;
                    end
                end
                if (end_rec) begin
                    record_counter_next = record_counter_reg + 16'd1;
                    records_left_next   = records_left_reg - 16'd1;
                    if (records_left_reg == 16'd1) begin
                        done_flag_next = 1'b1;
                        field_next     = F_TRAIL;
                    end else begin
                        field_next = F_REC_TYPE;
                    end
                end
            end
            if (final_byte && !done_flag_next) begin
                err = E_TRUNC;
            end
        end

        res.msg_kind   = kind_next;
        res.error_code = err;

        // last byte of a message: back to the start
        if (final_byte) begin
            kind_next           = K_UNDECIDED;
            field_next          = F_TYPE;
            byte_count_next     = 4'd0;
            records_left_next   = 16'd0;
            sources_left_next   = 16'd0;
            aux_words_left_next = 8'd0;
            record_counter_next = 16'd0;
            source_counter_next = 16'd0;
            value_acc_next      = 32'd0;
            done_flag_next      = 1'b0;
            type_next           = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg           <= K_UNDECIDED;
            field_reg          <= F_TYPE;
            byte_count_reg     <= 4'd0;
            records_left_reg   <= 16'd0;
            sources_left_reg   <= 16'd0;
            aux_words_left_reg <= 8'd0;
            record_counter_reg <= 16'd0;
            source_counter_reg <= 16'd0;
            value_acc_reg      <= 32'd0;
            done_flag_reg      <= 1'b0;
            type_reg           <= 8'd0;
        end else if (step) begin
            kind_reg           <= kind_next;
            field_reg          <= field_next;
            byte_count_reg     <= byte_count_next;
            records_left_reg   <= records_left_next;
            sources_left_reg   <= sources_left_next;
            aux_words_left_reg <= aux_words_left_next;
            record_counter_reg <= record_counter_next;
            source_counter_reg <= source_counter_next;
            value_acc_reg      <= value_acc_next;
            done_flag_reg      <= done_flag_next;
            type_reg           <= type_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_flag_reg |-> field_reg == F_TRAIL)
        else $error("complete structure without trailing field");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && final_byte |=> !done_flag_reg && field_reg == F_TYPE)
        else $error("state not cleared after final item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !done_flag_reg |-> ({1'b0, byte_count_reg} < field_len(field_reg)))
        else $error("byte position past field length");

endmodule
`default_nettype wire

// ===== src/mld_message_byte_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: each item passes the input register, then the result register.
// Throughput: 1 item per cycle unless m_ready stalls it; the field tracker state updates once per item.
// Reset: synchronous active-low aresetn clears the parse state and both valid flags.
// A result waiting on m_ready stalls the input register only when it is also full.
// ----------------------------------------------------------------------------
// MLD message byte parser
// Tags each byte of an MLD v1/v2 message with its field, assembles short
// field values and flags unsupported, truncated and excess bytes.
// ----------------------------------------------------------------------------
module mld_message_byte_parser_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          s_final_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mldp_pkg::KIND_W-1:0]        m_msg_kind,
    output logic [mldp_pkg::FIELD_W-1:0]       m_field_id,
    output logic [3:0]                         m_byte_in_field,
    output logic                               m_field_done,
    output logic [31:0]                        m_field_value,
    output logic [15:0]                        m_record_index,
    output logic [15:0]                        m_source_index,
    output logic [mldp_pkg::ERR_W-1:0]         m_error_code,
    output logic                               m_message_end
);
    import mldp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_final_reg;
    logic         out_valid_reg, out_valid_next;
    mldp_result_t out_reg;
    mldp_result_t res;
    logic         advance;
    logic         s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    mldp_field_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_accept) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_msg_kind      = out_reg.msg_kind;
    assign m_field_id      = out_reg.field_id;
    assign m_byte_in_field = out_reg.byte_in_field;
    assign m_field_done    = out_reg.field_done;
    assign m_field_value   = out_reg.field_value;
    assign m_record_index  = out_reg.record_index;
    assign m_source_index  = out_reg.source_index;
    assign m_error_code    = out_reg.error_code;
    assign m_message_end   = out_reg.message_end;

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("item moved but no result presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without downstream backpressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.field_id == F_TRAIL |-> out_reg.error_code == E_EXCESS)
        else $error("trailing item without excess flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.error_code == E_TRUNC |-> out_reg.message_end)
        else $error("truncation flagged on non-final item");

endmodule
`default_nettype wire
